/* rtl/core/assert_macros.svh */
// assertion macros shared by the rtl modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// combinational property checked at every rising clock edge out of reset
`define ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// same-cycle implication
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/ftfsa_pkg.sv */
// shared types and constants of the frame timer / fixed step accumulator
package ftfsa_pkg;

  // configuration port geometry
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ALPHA     = 3'd0,
    CFG_SCALE     = 3'd1,
    CFG_PAUSED    = 3'd2,
    CFG_STEP      = 3'd3,
    CFG_MAX_DELTA = 3'd4,
    CFG_MAX_ACCUM = 3'd5
  } cfg_idx_t;

  // item kinds
  localparam logic KIND_TICK  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // configuration reset values
  localparam logic [16:0] ALPHA_RST     = 17'd6554;
  localparam logic [15:0] SCALE_RST     = 16'd256;
  localparam logic        PAUSED_RST    = 1'b0;
  localparam logic [31:0] STEP_RST      = 32'd16667;
  localparam logic [31:0] MAX_DELTA_RST = 32'd250000;
  localparam logic [31:0] MAX_ACCUM_RST = 32'd250000;

  // arithmetic constants
  localparam logic [27:0] RATE_NUM      = 28'd256000000;
  localparam logic [16:0] ALPHA_ONE     = 17'h10000;
  localparam logic [4:0]  DIV_FIRST_BIT = 5'd27;

  // controller to datapath commands
  typedef struct packed {
    logic load_in;
    logic div_step;
    logic update;
    logic mul_smooth;
    logic mul_rate;
    logic smooth;
    logic mul_delta;
    logic scale;
    logic accum;
    logic query;
    logic load_out;
  } ctrl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic div_last;
  } dp_stat_t;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_UPDATE,
    ST_MUL_S,
    ST_MUL_R,
    ST_SMOOTH,
    ST_MUL_D,
    ST_SCALE,
    ST_ACCUM,
    ST_QUERY,
    ST_DONE
  } state_t;

endpackage

/* rtl/core/ftfsa_datapath.sv */
// datapath: config registers, serial divider, shared multiplier, state and output registers
`include "assert_macros.svh"

module ftfsa_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [ftfsa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ftfsa_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic [31:0]                         in_raw_delta_us,
  input  ftfsa_pkg::ctrl_cmd_t                cmd,
  output ftfsa_pkg::dp_stat_t                 stat,
  output logic                                out_step_due,
  output logic [31:0]                         out_sim_delta_us,
  output logic [27:0]                         out_fps,
  output logic [31:0]                         out_min_fps,
  output logic [27:0]                         out_max_fps,
  output logic [27:0]                         out_smoothed_fps,
  output logic [31:0]                         out_frame_count,
  output logic [31:0]                         out_accumulated_us
);

  // configuration registers
  logic [16:0] alpha_r;
  logic [15:0] scale_r;
  logic        paused_r;
  logic [31:0] step_r;
  logic [31:0] max_delta_r;
  logic [31:0] max_accum_r;

  // block state
  logic [27:0] rate_now_r;
  logic [31:0] rate_low_r;
  logic [27:0] rate_high_r;
  logic [27:0] rate_smooth_r;
  logic        seeded_r;
  logic [31:0] ticks_r;
  logic [31:0] sim_delta_r;
  logic [31:0] pending_r;

  // working registers
  logic [31:0] raw_r;
  logic [31:0] rem_r;
  logic [27:0] quo_r;
  logic [4:0]  div_cnt_r;
  logic [47:0] prod_r;
  logic [44:0] sum_r;
  logic        due_r;

  // output register
  logic        o_due_r;
  logic [31:0] o_sim_r;
  logic [27:0] o_fps_r;
  logic [31:0] o_min_r;
  logic [27:0] o_max_r;
  logic [27:0] o_smooth_r;
  logic [31:0] o_count_r;
  logic [31:0] o_pend_r;

  // combinational helpers
  logic [32:0] rem_sh;
  logic        rem_ge;
  logic [32:0] rem_diff;
  logic [27:0] rate;
  logic [16:0] alpha_sat;
  logic [16:0] one_minus;
  logic [31:0] clamped;
  logic [31:0] mul_a;
  logic [16:0] mul_b;
  logic [47:0] mul_p;
  logic [45:0] smooth_sum;
  logic [39:0] scaled_full;
  logic [31:0] scaled;
  logic [32:0] accum_sum;
  logic        step_ok;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r     <= ftfsa_pkg::ALPHA_RST;
      scale_r     <= ftfsa_pkg::SCALE_RST;
      paused_r    <= ftfsa_pkg::PAUSED_RST;
      step_r      <= ftfsa_pkg::STEP_RST;
      max_delta_r <= ftfsa_pkg::MAX_DELTA_RST;
      max_accum_r <= ftfsa_pkg::MAX_ACCUM_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        ftfsa_pkg::CFG_ALPHA:     alpha_r     <= cfg_wdata[16:0];
        ftfsa_pkg::CFG_SCALE:     scale_r     <= cfg_wdata[15:0];
        ftfsa_pkg::CFG_PAUSED:    paused_r    <= cfg_wdata[0];
        ftfsa_pkg::CFG_STEP:      step_r      <= cfg_wdata;
        ftfsa_pkg::CFG_MAX_DELTA: max_delta_r <= cfg_wdata;
        ftfsa_pkg::CFG_MAX_ACCUM: max_accum_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // restoring divider step, one quotient bit per cycle
  always_comb begin
    rem_sh   = {rem_r, ftfsa_pkg::RATE_NUM[div_cnt_r]};
    rem_ge   = rem_sh >= {1'b0, raw_r};
    rem_diff = rem_sh - {1'b0, raw_r};
  end

  assign stat.div_last = (div_cnt_r == 5'd0);

  // zero interval gives rate zero
  assign rate = (raw_r == 32'd0) ? 28'd0 : quo_r;

  // smoothing weight and clamped interval
  assign alpha_sat = (alpha_r > ftfsa_pkg::ALPHA_ONE) ? ftfsa_pkg::ALPHA_ONE : alpha_r;
  assign one_minus = ftfsa_pkg::ALPHA_ONE - alpha_sat;
  assign clamped   = (raw_r < max_delta_r) ? raw_r : max_delta_r;

  // shared multiplier operand select
  always_comb begin
    if (cmd.mul_smooth) begin
      mul_a = {4'd0, rate_smooth_r};
      mul_b = one_minus;
    end else if (cmd.mul_rate) begin
      mul_a = {4'd0, rate_now_r};
      mul_b = alpha_sat;
    end else begin
      mul_a = clamped;
      mul_b = {1'b0, scale_r};
    end
  end

  assign mul_p = {16'd0, mul_a} * {31'd0, mul_b};

  // smoothing sum, scaling and accumulation
  assign smooth_sum  = {1'b0, sum_r} + {1'b0, prod_r[44:0]};
  assign scaled_full = prod_r[47:8];
  assign scaled      = (|scaled_full[39:32]) ? 32'hFFFF_FFFF : scaled_full[31:0];
  assign accum_sum   = {1'b0, pending_r} + {1'b0, sim_delta_r};
  assign step_ok     = (step_r != 32'd0) && (pending_r >= step_r);

  // block state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_now_r    <= 28'd0;
      rate_low_r    <= 32'hFFFF_FFFF;
      rate_high_r   <= 28'd0;
      rate_smooth_r <= 28'd0;
      seeded_r      <= 1'b0;
      ticks_r       <= 32'd0;
      sim_delta_r   <= 32'd0;
      pending_r     <= 32'd0;
    end else begin
      if (cmd.update) begin
        rate_now_r <= rate;
        ticks_r    <= ticks_r + 32'd1;
        if (rate != 28'd0) begin
          if ({4'd0, rate} < rate_low_r) begin
            rate_low_r <= {4'd0, rate};
          end
          if (rate > rate_high_r) begin
            rate_high_r <= rate;
          end
        end
      end
      if (cmd.smooth) begin
        seeded_r <= 1'b1;
        if (seeded_r) begin
          rate_smooth_r <= smooth_sum[43:16];
        end else begin
          rate_smooth_r <= rate_now_r;
        end
      end
      if (cmd.scale) begin
        sim_delta_r <= paused_r ? 32'd0 : scaled;
      end
      if (cmd.accum) begin
        pending_r <= (accum_sum > {1'b0, max_accum_r}) ? max_accum_r : accum_sum[31:0];
      end else if (cmd.query && step_ok) begin
        pending_r <= pending_r - step_r;
      end
    end
  end

  // divider and multiplier working registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      raw_r     <= in_raw_delta_us;
      rem_r     <= 32'd0;
      quo_r     <= 28'd0;
      div_cnt_r <= ftfsa_pkg::DIV_FIRST_BIT;
      due_r     <= 1'b0;
    end else begin
      if (cmd.div_step) begin
        rem_r     <= rem_ge ? rem_diff[31:0] : rem_sh[31:0];
        quo_r     <= {quo_r[26:0], rem_ge};
        div_cnt_r <= div_cnt_r - 5'd1;
      end
      if (cmd.query) begin
        due_r <= step_ok;
      end
    end
    if (cmd.mul_smooth || cmd.mul_rate || cmd.mul_delta) begin
      prod_r <= mul_p;
    end
    if (cmd.mul_rate) begin
      sum_r <= prod_r[44:0];
    end
  end

  // result snapshot
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      o_due_r    <= due_r;
      o_sim_r    <= sim_delta_r;
      o_fps_r    <= rate_now_r;
      o_min_r    <= rate_low_r;
      o_max_r    <= rate_high_r;
      o_smooth_r <= rate_smooth_r;
      o_count_r  <= ticks_r;
      o_pend_r   <= pending_r;
    end
  end

  assign out_step_due       = o_due_r;
  assign out_sim_delta_us   = o_sim_r;
  assign out_fps            = o_fps_r;
  assign out_min_fps        = o_min_r;
  assign out_max_fps        = o_max_r;
  assign out_smoothed_fps   = o_smooth_r;
  assign out_frame_count    = o_count_r;
  assign out_accumulated_us = o_pend_r;

  // once a nonzero rate was seen the minimum never exceeds the maximum
  `ASSERT_IMPLIES(a_min_le_max, rate_low_r != 32'hFFFF_FFFF, (rate_low_r[31:28] == 4'd0) && (rate_low_r[27:0] <= rate_high_r), "rate minimum above maximum")

endmodule

/* rtl/core/ftfsa_ctrl.sv */
// sequencer: divide, update, smooth, scale and accumulate a tick, or step-check a query
`include "assert_macros.svh"

module ftfsa_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_kind,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  ftfsa_pkg::dp_stat_t  stat,
  output ftfsa_pkg::ctrl_cmd_t cmd
);

  ftfsa_pkg::state_t state_r;
  ftfsa_pkg::state_t state_nxt;
  logic              out_valid_r;
  logic              out_valid_nxt;
  logic              out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ftfsa_pkg::ST_IDLE);
  assign out_valid = out_valid_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ftfsa_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_kind == ftfsa_pkg::KIND_QUERY) ? ftfsa_pkg::ST_QUERY
                                                         : ftfsa_pkg::ST_DIV;
        end
      end
      ftfsa_pkg::ST_DIV: begin
        if (stat.div_last) begin
          state_nxt = ftfsa_pkg::ST_UPDATE;
        end
      end
      ftfsa_pkg::ST_UPDATE: state_nxt = ftfsa_pkg::ST_MUL_S;
      ftfsa_pkg::ST_MUL_S:  state_nxt = ftfsa_pkg::ST_MUL_R;
      ftfsa_pkg::ST_MUL_R:  state_nxt = ftfsa_pkg::ST_SMOOTH;
      ftfsa_pkg::ST_SMOOTH: state_nxt = ftfsa_pkg::ST_MUL_D;
      ftfsa_pkg::ST_MUL_D:  state_nxt = ftfsa_pkg::ST_SCALE;
      ftfsa_pkg::ST_SCALE:  state_nxt = ftfsa_pkg::ST_ACCUM;
      ftfsa_pkg::ST_ACCUM:  state_nxt = ftfsa_pkg::ST_DONE;
      ftfsa_pkg::ST_QUERY:  state_nxt = ftfsa_pkg::ST_DONE;
      ftfsa_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = ftfsa_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ftfsa_pkg::ST_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd = '0;
    case (state_r)
      ftfsa_pkg::ST_IDLE:   cmd.load_in    = in_valid;
      ftfsa_pkg::ST_DIV:    cmd.div_step   = 1'b1;
      ftfsa_pkg::ST_UPDATE: cmd.update     = 1'b1;
      ftfsa_pkg::ST_MUL_S:  cmd.mul_smooth = 1'b1;
      ftfsa_pkg::ST_MUL_R:  cmd.mul_rate   = 1'b1;
      ftfsa_pkg::ST_SMOOTH: cmd.smooth     = 1'b1;
      ftfsa_pkg::ST_MUL_D:  cmd.mul_delta  = 1'b1;
      ftfsa_pkg::ST_SCALE:  cmd.scale      = 1'b1;
      ftfsa_pkg::ST_ACCUM:  cmd.accum      = 1'b1;
      ftfsa_pkg::ST_QUERY:  cmd.query      = 1'b1;
      ftfsa_pkg::ST_DONE:   cmd.load_out   = out_free;
      default: cmd = '0;
    endcase
  end

  // output slot occupancy
  assign out_valid_nxt = cmd.load_out ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ftfsa_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // an accepted item always starts work
  `ASSERT_NEXT(a_accept_busy, in_valid && !in_stall, state_r != ftfsa_pkg::ST_IDLE, "accepted item did not start")
  // divider keeps iterating until its last bit
  `ASSERT_NEXT(a_div_hold, (state_r == ftfsa_pkg::ST_DIV) && !stat.div_last, state_r == ftfsa_pkg::ST_DIV, "divider left early")
  // a result never overwrites one still waiting
  `ASSERT_IMPLIES(a_no_overwrite, cmd.load_out, !out_valid_r || !out_stall, "result overwritten")

endmodule

/* rtl/core/frame_timer_fixed_step_accumulator.sv */
// top level of the frame timer with fixed step accumulator and frame rate meter
//
//   channel  direction  handshake           payload
//   in       input      in_valid/in_stall   in_kind, in_raw_delta_us
//   out      output     out_valid/out_stall out_step_due .. out_accumulated_us
//   cfg      input      cfg_we              cfg_index, cfg_wdata
//
// a tick is taken through the bit-serial reciprocal divider, then through seven single steps
// (update, three products on the shared 32x17 multiplier, smoothing, scaling, accumulation),
// and then its result is loaded into the output register; a query goes through the step check alone.
// the next item is taken in the cycle after the load; a result still waiting in the output
// register holds the load back. reset is synchronous; it restores the register defaults and
// clears the block state and sequencer, but the working and output registers are not reset.
module frame_timer_fixed_step_accumulator (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [ftfsa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ftfsa_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_kind,
  input  logic [31:0]                      in_raw_delta_us,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_step_due,
  output logic [31:0]                      out_sim_delta_us,
  output logic [27:0]                      out_fps,
  output logic [31:0]                      out_min_fps,
  output logic [27:0]                      out_max_fps,
  output logic [27:0]                      out_smoothed_fps,
  output logic [31:0]                      out_frame_count,
  output logic [31:0]                      out_accumulated_us
);

  ftfsa_pkg::ctrl_cmd_t cmd;
  ftfsa_pkg::dp_stat_t  stat;

  // sequencer
  ftfsa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_kind   (in_kind),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // arithmetic and state
  ftfsa_datapath u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_raw_delta_us    (in_raw_delta_us),
    .cmd                (cmd),
    .stat               (stat),
    .out_step_due       (out_step_due),
    .out_sim_delta_us   (out_sim_delta_us),
    .out_fps            (out_fps),
    .out_min_fps        (out_min_fps),
    .out_max_fps        (out_max_fps),
    .out_smoothed_fps   (out_smoothed_fps),
    .out_frame_count    (out_frame_count),
    .out_accumulated_us (out_accumulated_us)
  );

endmodule
